FILE: sv/assert_macros.svh
// Assertion macros used by the top RTL file of the axis-angle rotation block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AXR_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The condition must never hold outside reset.
`define AXR_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

`endif

FILE: sv/axr_pkg.sv
// Package for the axis-angle to rotation matrix block: payload and pipeline
// types, CORDIC constants, arctangent table and the output rounding function.
`default_nettype none
package axr_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_RUN = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int STEP_BITS = 5;
   localparam int CW = 34;

   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
   localparam logic signed [16:0] QUARTER = 17'sd16384;
   localparam logic signed [16:0] HALF = 17'sd32768;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic [15:0] angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] r00;
      logic signed [15:0] r01;
      logic signed [15:0] r02;
      logic signed [15:0] r10;
      logic signed [15:0] r11;
      logic signed [15:0] r12;
      logic signed [15:0] r20;
      logic signed [15:0] r21;
      logic signed [15:0] r22;
   } rsp_type;

   // One slot of the CORDIC chain.
   typedef struct packed {
      logic valid;
      logic zero;
      logic flip;
      logic signed [15:0] kx;
      logic signed [15:0] ky;
      logic signed [15:0] kz;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } pipe_type;

   // Arctangent of 2^-i in units of 2^32 per turn.
   function automatic logic signed [CW-1:0] atan_at(input logic [STEP_BITS-1:0] idx);
      logic signed [CW-1:0] t;
      case (idx)
         5'd0: t = 34'sd536870912;
         5'd1: t = 34'sd316933406;
         5'd2: t = 34'sd167458907;
         5'd3: t = 34'sd85004756;
         5'd4: t = 34'sd42667331;
         5'd5: t = 34'sd21354465;
         5'd6: t = 34'sd10679838;
         5'd7: t = 34'sd5340245;
         5'd8: t = 34'sd2670163;
         5'd9: t = 34'sd1335087;
         5'd10: t = 34'sd667544;
         5'd11: t = 34'sd333772;
         5'd12: t = 34'sd166886;
         5'd13: t = 34'sd83443;
         5'd14: t = 34'sd41722;
         5'd15: t = 34'sd20861;
         5'd16: t = 34'sd10430;
         5'd17: t = 34'sd5215;
         5'd18: t = 34'sd2608;
         5'd19: t = 34'sd1304;
         5'd20: t = 34'sd652;
         5'd21: t = 34'sd326;
         5'd22: t = 34'sd163;
         5'd23: t = 34'sd81;
         default: t = '0;
      endcase
      return t;
   endfunction

   // Round a Q58 sum half up to Q14 and saturate to 16 bits.
   function automatic logic signed [15:0] finish(input logic signed [65:0] q58);
      logic signed [65:0] biased;
      logic signed [21:0] r;
      logic signed [15:0] res;
      biased = q58 + 66'sd8796093022208;
      r = 22'(biased >>> 44);
      if (r > 22'sd32767) begin
         res = 16'sh7fff;
      end else if (r < -22'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = r[15:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: sv/axr_cordic_cell.sv
// One CORDIC rotation step with its output register.
// Depends on axr_pkg.
`default_nettype none
module axr_cordic_cell
   import axr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic [STEP_BITS-1:0] step_idx,
   input wire pipe_type stage_in,
   output pipe_type stage_out
);

   pipe_type stage_ff;
   pipe_type stage_nx_in;
   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;
   logic signed [CW-1:0] ang;

   // Rotate toward zero residual angle; reset drops the valid flag.
   always_comb begin
      dx = stage_in.y >>> step_idx;
      dy = stage_in.x >>> step_idx;
      ang = atan_at(step_idx);
      stage_nx_in = stage_in;
      stage_nx_in.valid = stage_in.valid && !reset;
      if (!stage_in.z[CW-1]) begin
         stage_nx_in.x = stage_in.x - dx;
         stage_nx_in.y = stage_in.y + dy;
         stage_nx_in.z = stage_in.z - ang;
      end else begin
         stage_nx_in.x = stage_in.x + dx;
         stage_nx_in.y = stage_in.y - dy;
         stage_nx_in.z = stage_in.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_nx_in;
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

FILE: sv/axr_matrix.sv
// Rodrigues matrix assembly: sign fix, axis products, products with sine
// and versine, then sums with rounding and saturation. Depends on axr_pkg.
`default_nettype none
module axr_matrix
   import axr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire pipe_type stage_in,
   output logic rsp_strobe,
   output rsp_type rsp_data,
   output logic mid_valid
);

   // Stage A: cosine, sine, versine and axis products.
   logic a_valid_ff, a_zero_ff;
   logic signed [CW-1:0] c_ff, s_ff, v_ff, c_in, s_in;
   logic signed [15:0] kx_ff, ky_ff, kz_ff;
   logic signed [31:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;

   assign c_in = stage_in.flip ? -stage_in.x : stage_in.x;
   assign s_in = stage_in.flip ? -stage_in.y : stage_in.y;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= stage_in.valid;
      end
      a_zero_ff <= stage_in.zero;
      c_ff <= c_in;
      s_ff <= s_in;
      v_ff <= ONE_Q30 - c_in;
      kx_ff <= stage_in.kx;
      ky_ff <= stage_in.ky;
      kz_ff <= stage_in.kz;
      xx_ff <= stage_in.kx * stage_in.kx;
      yy_ff <= stage_in.ky * stage_in.ky;
      zz_ff <= stage_in.kz * stage_in.kz;
      xy_ff <= stage_in.kx * stage_in.ky;
      xz_ff <= stage_in.kx * stage_in.kz;
      yz_ff <= stage_in.ky * stage_in.kz;
   end

   // Stage B: products with the versine and the sine, all in Q58.
   logic b_valid_ff, b_zero_ff;
   logic signed [65:0] mxx_ff, myy_ff, mzz_ff, mxy_ff, mxz_ff, myz_ff;
   logic signed [49:0] sx_in, sy_in, sz_in;
   logic signed [63:0] sx_ff, sy_ff, sz_ff;
   logic signed [61:0] cq_ff;

   assign sx_in = kx_ff * s_ff;
   assign sy_in = ky_ff * s_ff;
   assign sz_in = kz_ff * s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_zero_ff <= a_zero_ff;
      mxx_ff <= xx_ff * v_ff;
      myy_ff <= yy_ff * v_ff;
      mzz_ff <= zz_ff * v_ff;
      mxy_ff <= xy_ff * v_ff;
      mxz_ff <= xz_ff * v_ff;
      myz_ff <= yz_ff * v_ff;
      sx_ff <= $signed({sx_in, 14'b0});
      sy_ff <= $signed({sy_in, 14'b0});
      sz_ff <= $signed({sz_in, 14'b0});
      cq_ff <= $signed({c_ff, 28'b0});
   end

   // Stage C: sums, rounding and saturation into the result register, or the identity for a zero angle.
   logic c_valid_ff;
   rsp_type res_ff, res_in;
   logic signed [65:0] cq66, sx66, sy66, sz66;

   assign cq66 = 66'(cq_ff);
   assign sx66 = 66'(sx_ff);
   assign sy66 = 66'(sy_ff);
   assign sz66 = 66'(sz_ff);

   always_comb begin
      if (b_zero_ff) begin
         res_in = '0;
         res_in.r00 = ONE_Q14;
         res_in.r11 = ONE_Q14;
         res_in.r22 = ONE_Q14;
      end else begin
         res_in.r00 = finish(mxx_ff + cq66);
         res_in.r01 = finish(mxy_ff - sz66);
         res_in.r02 = finish(mxz_ff + sy66);
         res_in.r10 = finish(mxy_ff + sz66);
         res_in.r11 = finish(myy_ff + cq66);
         res_in.r12 = finish(myz_ff - sx66);
         res_in.r20 = finish(mxz_ff - sy66);
         res_in.r21 = finish(myz_ff + sx66);
         res_in.r22 = finish(mzz_ff + cq66);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      res_ff <= res_in;
   end

   assign rsp_strobe = c_valid_ff;
   assign rsp_data = res_ff;
   assign mid_valid = b_valid_ff;

endmodule
`default_nettype wire

FILE: sv/angle_axis_to_rotation_matrix.sv
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// The pipeline is the input register, 16 CORDIC cells and three product stages.
// Reset clears the valid flags of every stage; results are never held off.
// Depends on axr_pkg, axr_cordic_cell, axr_matrix and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module angle_axis_to_rotation_matrix
   import axr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire req_type req_data,
   output logic rsp_strobe,
   output rsp_type rsp_data
);

   pipe_type chain [0:CORDIC_RUN];
   pipe_type head_ff, head_in;
   logic signed [16:0] ang_s, ang_red;
   logic mid_valid;

   assign busy = 1'b0;

   // Fold the angle into a quarter turn either side of zero.
   always_comb begin
      ang_s = 17'($signed(req_data.angle));
      head_in.flip = 1'b0;
      ang_red = ang_s;
      if (ang_s > QUARTER) begin
         ang_red = ang_s - HALF;
         head_in.flip = 1'b1;
      end else if (ang_s < -QUARTER) begin
         ang_red = ang_s + HALF;
         head_in.flip = 1'b1;
      end
      head_in.valid = start && !busy && !reset;
      head_in.zero = (req_data.angle == 16'd0);
      head_in.kx = req_data.axis_x;
      head_in.ky = req_data.axis_y;
      head_in.kz = req_data.axis_z;
      head_in.x = CORDIC_X0;
      head_in.y = '0;
      head_in.z = CW'($signed({ang_red, 16'b0}));
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

   assign chain[0] = head_ff;

   // Row of CORDIC cells, one rotation step each.
   genvar g;
   generate
      for (g = 0; g < CORDIC_RUN; g++) begin : g_cell
         axr_cordic_cell u_cell (
            .clock(clock),
            .reset(reset),
            .step_idx(STEP_BITS'(g)),
            .stage_in(chain[g]),
            .stage_out(chain[g+1])
         );
      end
   endgenerate

   axr_matrix u_matrix (
      .clock(clock),
      .reset(reset),
      .stage_in(chain[CORDIC_RUN]),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .mid_valid(mid_valid)
   );

   `AXR_NEVER(busy_never_high, clock, reset, busy)
   `AXR_IMPLIES(strobe_follows_stage, clock, reset, rsp_strobe, $past(mid_valid))
   `AXR_IMPLIES(stage_follows_chain, clock, reset, mid_valid, $past(chain[CORDIC_RUN].valid, 2))

endmodule
`default_nettype wire

FILE: tb/angle_axis_to_rotation_matrix_checker.sv
// Checker for the angle-axis to rotation matrix block: watches both channels,
// predicts each matrix with a CORDIC and Rodrigues formula model, and compares.
// Depends on axr_pkg for the payload types and the CORDIC step count.
`timescale 1ns / 1ps
module angle_axis_to_rotation_matrix_checker
   import axr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire req_type req_data,
   input wire logic rsp_strobe,
   input wire rsp_type rsp_data,
   output int errors,
   output int pending,
   output int matrices_seen
);

   // Arctangent of 2^-i, 2^32 units per turn.
   localparam longint ATAN_TURN [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};
   localparam longint GAIN_X0 = 652032874;
   localparam longint UNIT_Q30 = 1073741824;

   rsp_type matrix_queue[$];

   // Round a Q58 sum half up to Q14 and clamp to 16 bits.
   function automatic logic [15:0] round_q14(input longint q58);
      longint r;
      r = (q58 + (longint'(1) <<< 43)) >>> 44;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // Rotation matrix for one axis and angle.
   function automatic rsp_type rotation_of(input req_type q);
      rsp_type m;
      longint kx, ky, kz, a, x, y, z, dx, dy, c, s, v, cq, sx, sy, sz, xy, xz, yz;
      logic signed [15:0] sa;
      bit flip;
      int steps;
      kx = q.axis_x;
      ky = q.axis_y;
      kz = q.axis_z;
      sa = q.angle;
      a = sa;
      flip = 0;
      if (a == 0) begin
         m = '0;
         m.r00 = 16'sd16384;
         m.r11 = 16'sd16384;
         m.r22 = 16'sd16384;
         return m;
      end
      // Fold the angle into the right half plane; sine and cosine flip sign.
      if (a > 16384) begin
         a -= 32768;
         flip = 1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1;
      end
      x = GAIN_X0;
      y = 0;
      z = a * 65536;
      steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
      for (int i = 0; i < steps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ATAN_TURN[i];
         end else begin
            x += dx;
            y -= dy;
            z += ATAN_TURN[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
      v = UNIT_Q30 - c;
      cq = c * (longint'(1) <<< 28);
      sx = kx * s * 16384;
      sy = ky * s * 16384;
      sz = kz * s * 16384;
      xy = kx * ky * v;
      xz = kx * kz * v;
      yz = ky * kz * v;
      m.r00 = round_q14(kx * kx * v + cq);
      m.r01 = round_q14(xy - sz);
      m.r02 = round_q14(xz + sy);
      m.r10 = round_q14(xy + sz);
      m.r11 = round_q14(ky * ky * v + cq);
      m.r12 = round_q14(yz - sx);
      m.r20 = round_q14(xz - sy);
      m.r21 = round_q14(yz + sx);
      m.r22 = round_q14(kz * kz * v + cq);
      return m;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // Compare each result transfer with the oldest prediction, then record new requests.
   always @(posedge clock) begin
      rsp_type want;
      logic [143:0] gbits, wbits;
      string names [9];
      names = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
      if (reset) begin
         matrix_queue.delete();
      end else begin
         if (rsp_strobe) begin
            matrices_seen++;
            if (matrix_queue.size() == 0) begin
               report("unexpected result", 0, 0);
            end else begin
               want = matrix_queue.pop_front();
               gbits = rsp_data;
               wbits = want;
               for (int n = 0; n < 9; n++) begin
                  if (gbits[143 - 16 * n -: 16] !== wbits[143 - 16 * n -: 16]) begin
                     report(names[n], $signed(gbits[143 - 16 * n -: 16]),
                            $signed(wbits[143 - 16 * n -: 16]));
                  end
               end
            end
         end
         if (start && !busy) begin
            matrix_queue.push_back(rotation_of(req_data));
         end
      end
      pending = matrix_queue.size();
   end

   initial begin
      errors = 0;
      pending = 0;
      matrices_seen = 0;
   end

endmodule

FILE: tb/angle_axis_to_rotation_matrix_tb.sv
// Top of the testbench for angle_axis_to_rotation_matrix: clock, reset, directed
// and random poses with random gaps, watchdog and verdict.
// Depends on axr_pkg, the block and angle_axis_to_rotation_matrix_checker.
`timescale 1ns / 1ps
module angle_axis_to_rotation_matrix_tb;
   import axr_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_POSES = 700;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_strobe;
   rsp_type rsp_data;
   int errors, pending, matrices_seen;
   int poses_sent;
   int idle_cycles;
   bit steady;

   angle_axis_to_rotation_matrix dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   angle_axis_to_rotation_matrix_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .errors(errors), .pending(pending), .matrices_seen(matrices_seen)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watchdog: ends the run after too many cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly short gaps, a few long ones; none while in a steady stretch.
   function automatic int gap_length();
      int p;
      if (steady) return 0;
      p = $urandom_range(99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic send_pose(input logic [15:0] kx, input logic [15:0] ky,
                            input logic [15:0] kz, input logic [15:0] ang);
      int gap;
      req_data <= '{axis_x: kx, axis_y: ky, axis_z: kz, angle: ang};
      start <= 1'b1;
      do @(posedge clock); while (busy);
      poses_sent++;
      gap = gap_length();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] unit_ish();
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   function automatic logic [15:0] pick_angle();
      int p;
      p = $urandom_range(99);
      if (p < 5) return 16'h0000;
      if (p < 20) return 16'($urandom_range(2) + {14'($urandom_range(3)), 14'h0} - 1);
      return 16'($urandom);
   endfunction

   initial begin
      logic [15:0] kx, ky, kz;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      poses_sent = 0;
      idle_cycles = 0;
      steady = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero angle, quadrant boundaries, half turn, axis extremes.
      send_pose(16'sd16384, 16'sd0, 16'sd0, 16'h0000);
      send_pose(16'h8000, 16'h7fff, 16'hffff, 16'h0000);
      send_pose(16'sd16384, 16'sd0, 16'sd0, 16'h4000);
      send_pose(16'sd0, 16'sd16384, 16'sd0, 16'h4001);
      send_pose(16'sd0, 16'sd0, 16'sd16384, 16'hc000);
      send_pose(16'sd0, 16'sd0, -16'sd16384, 16'hbfff);
      send_pose(-16'sd16384, 16'sd0, 16'sd0, 16'h8000);
      send_pose(16'sd0, -16'sd16384, 16'sd0, 16'h7fff);
      send_pose(16'sd9459, 16'sd9459, 16'sd9459, 16'h0001);
      send_pose(16'sd9459, -16'sd9459, 16'sd9459, 16'hffff);
      send_pose(16'h8000, 16'h8000, 16'h8000, 16'h2000);
      send_pose(16'h7fff, 16'h7fff, 16'h7fff, 16'ha000);
      send_pose(16'h8000, 16'h7fff, 16'h8000, 16'h6000);
      send_pose(16'h7fff, 16'h8000, 16'h7fff, 16'he000);
      send_pose(16'sd0, 16'sd0, 16'sd0, 16'h5555);
      send_pose(16'hffff, 16'h0001, 16'hffff, 16'haaaa);
      send_pose(16'sd11585, 16'sd11585, 16'sd0, 16'h1000);

      // Random: mostly in-range axes, some with full 16-bit components.
      for (int n = 0; n < RANDOM_POSES; n++) begin
         if (n % 50 == 0) steady = ($urandom_range(3) == 0);
         if ($urandom_range(99) < 75) begin
            kx = unit_ish();
            ky = unit_ish();
            kz = unit_ish();
         end else begin
            kx = 16'($urandom);
            ky = 16'($urandom);
            kz = 16'($urandom);
         end
         send_pose(kx, ky, kz, pick_angle());
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Sent %0d poses (directed edge cases and random axes and angles).", poses_sent);
      $display("Checked %0d rotation matrices, %0d mismatches.", matrices_seen, errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: angle_axis_to_rotation_matrix.f
+incdir+sv
sv/axr_pkg.sv
sv/axr_cordic_cell.sv
sv/axr_matrix.sv
sv/angle_axis_to_rotation_matrix.sv
tb/angle_axis_to_rotation_matrix_checker.sv
tb/angle_axis_to_rotation_matrix_tb.sv
